// File: hdl/q8dot_pkg.sv
// ----------------------------------------------------------------------------
// q8dot_pkg
// Shared types and constants for the q8_0 block dot product core.
// ----------------------------------------------------------------------------
package q8dot_pkg;

  localparam int LANES_DEF      = 8;
  localparam int BYTES_PER_WORD = 8;
  localparam int SUM_W          = 21;
  localparam int PROD_W         = 16;
  localparam int HALF_W         = 16;
  localparam int FLT_W          = 32;
  localparam logic [FLT_W-1:0] CANON_NAN = 32'h7FC0_0000;

  typedef enum logic [3:0] {
    F_IDLE,
    F_MUL1,
    F_MUL2,
    F_LZC,
    F_TERM,
    F_ALIGN,
    F_ADD,
    F_LZC2,
    F_ROUND,
    F_DONE
  } fpu_state_t;

  // Closed block handed from the merge stage to the float unit
  typedef struct packed {
    logic                    start;
    logic                    row;
    logic signed [SUM_W-1:0] sum;
    logic [HALF_W-1:0]       wscale;
    logic [HALF_W-1:0]       ascale;
  } blk_req_t;

endpackage

// File: hdl/q8_0_block_dot_product_core.sv
// ----------------------------------------------------------------------------
// q8_0_block_dot_product_core
// Row dot product of two q8_0 rows, eight byte pairs per transaction.
// ----------------------------------------------------------------------------
//  channel  signals                                        direction
//  item     item_valid/item_stall, weight_bytes, act_bytes, in
//           weight_scale, act_scale, block_end, row_end
//  dot      dot_valid/dot_stall, dot_value                  out
//
//  Chunks inside a block are taken one per cycle through the lane products.
//  A chunk that closes a block holds item_stall while the shared float unit
//  scales and accumulates the block sum, and at a row end until the result is emitted.
//  The dot_value register lets the next row start while a result waits.
//  Reset clears the block sum, the row sum and all valid flags.
// ----------------------------------------------------------------------------
module q8_0_block_dot_product_core import q8dot_pkg::*; #(
  parameter int LANES = LANES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  logic [63:0]      weight_bytes,
  input  logic [63:0]      act_bytes,
  input  logic [15:0]      weight_scale,
  input  logic [15:0]      act_scale,
  input  logic             block_end,
  input  logic             row_end,
  output logic             dot_valid,
  input  logic             dot_stall,
  output logic [31:0]      dot_value
);

  localparam int NL = (LANES < BYTES_PER_WORD) ? LANES : BYTES_PER_WORD;

  logic                     accept;
  logic                     s1_valid;
  logic                     s1_bend;
  logic                     s1_rend;
  logic [HALF_W-1:0]        s1_wscale;
  logic [HALF_W-1:0]        s1_ascale;
  logic signed [PROD_W-1:0] prods [NL];
  blk_req_t                 req;
  logic                     fpu_busy;

  assign item_stall = fpu_busy | req.start | (s1_valid & s1_bend);
  assign accept     = item_valid & ~item_stall;

  for (genvar g = 0; g < NL; g++) begin : g_lane
    q8dot_lane u_lane (
      .clk   (clk),
      .en    (accept),
      .wbyte (weight_bytes[8*g +: 8]),
      .abyte (act_bytes[8*g +: 8]),
      .prod  (prods[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_bend   <= block_end | row_end;
      s1_rend   <= row_end;
      s1_wscale <= weight_scale;
      s1_ascale <= act_scale;
    end
  end

  q8dot_merge #(.NL(NL)) u_merge (
    .clk       (clk),
    .rst       (rst),
    .s1_valid  (s1_valid),
    .s1_bend   (s1_bend),
    .s1_rend   (s1_rend),
    .s1_wscale (s1_wscale),
    .s1_ascale (s1_ascale),
    .prods     (prods),
    .req       (req)
  );

  q8dot_fpu u_fpu (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .dot_stall (dot_stall),
    .busy      (fpu_busy),
    .dot_valid (dot_valid),
    .dot_value (dot_value)
  );

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    req.start |-> !fpu_busy)
    else $error("block closed while float unit busy");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    req.start |=> fpu_busy)
    else $error("float unit did not take closed block");

  a_nan_canon: assert property (@(posedge clk) disable iff (rst)
    (dot_valid && (dot_value[30:23] == 8'hFF) && (dot_value[22:0] != 23'd0))
      |-> (dot_value == CANON_NAN))
    else $error("non-canonical NaN result");

endmodule

// File: hdl/q8dot_lane.sv
// ----------------------------------------------------------------------------
// q8dot_lane
// One lane: signed byte by signed byte product, registered.
// ----------------------------------------------------------------------------
module q8dot_lane import q8dot_pkg::*; (
  input  logic                     clk,
  input  logic                     en,
  input  logic [7:0]               wbyte,
  input  logic [7:0]               abyte,
  output logic signed [PROD_W-1:0] prod
);

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= $signed(wbyte) * $signed(abyte);
    end
  end

endmodule

// File: hdl/q8dot_merge.sv
// ----------------------------------------------------------------------------
// q8dot_merge
// Merges the lane products into the exact block sum and closes blocks.
// ----------------------------------------------------------------------------
module q8dot_merge import q8dot_pkg::*; #(
  parameter int NL = LANES_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s1_valid,
  input  logic                     s1_bend,
  input  logic                     s1_rend,
  input  logic [HALF_W-1:0]        s1_wscale,
  input  logic [HALF_W-1:0]        s1_ascale,
  input  logic signed [PROD_W-1:0] prods [NL],
  output blk_req_t                 req
);

  logic signed [SUM_W-1:0] block_sum;
  logic signed [SUM_W-1:0] total;

  always_comb begin
    total = block_sum;
    for (int i = 0; i < NL; i++) begin
      total = total + SUM_W'(prods[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_sum <= '0;
      req.start <= 1'b0;
    end else begin
      req.start <= s1_valid & s1_bend;
      if (s1_valid) begin
        // clear on block close, otherwise keep adding (wraps)
        block_sum <= s1_bend ? '0 : total;
      end
    end
    if (s1_valid && s1_bend) begin
      req.row    <= s1_rend;
      req.sum    <= total;
      req.wscale <= s1_wscale;
      req.ascale <= s1_ascale;
    end
  end

endmodule

// File: hdl/q8dot_fpu.sv
// ----------------------------------------------------------------------------
// q8dot_fpu
// Scales a closed block sum and adds it to the single-precision row sum.
// ----------------------------------------------------------------------------
module q8dot_fpu import q8dot_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  blk_req_t         req,
  input  logic             dot_stall,
  output logic             busy,
  output logic             dot_valid,
  output logic [FLT_W-1:0] dot_value
);

  fpu_state_t state, state_next;

  logic                    row;
  logic signed [SUM_W-1:0] bsum;
  logic [HALF_W-1:0]       ws;
  logic [HALF_W-1:0]       as;
  logic [SUM_W-1:0]        sabs;
  logic [21:0]             mm;
  logic [5:0]              esum;
  logic                    tsign;
  logic                    t_nan;
  logic                    t_inf;
  logic [41:0]             pp;
  logic [5:0]              psh;
  logic                    pzero;
  logic [FLT_W-1:0]        term;
  logic [FLT_W-1:0]        acc;
  logic [26:0]             xa;
  logic [26:0]             ya;
  logic [7:0]              xe;
  logic                    xs;
  logic                    sub;
  logic                    sp;
  logic [FLT_W-1:0]        spres;
  logic [27:0]             rr;
  logic [4:0]              shl;
  logic                    rmode;
  logic                    rzero;

  function automatic logic [5:0] lead_pos(input logic [41:0] v);
    logic [5:0] p;
    p = '0;
    for (int i = 0; i < 42; i++) begin
      if (v[i]) p = 6'(i);
    end
    return p;
  endfunction

  function automatic logic [4:0] lead_zeros(input logic [26:0] v);
    logic [4:0] z;
    z = 5'd27;
    for (int i = 0; i < 27; i++) begin
      if (v[i]) z = 5'(26 - i);
    end
    return z;
  endfunction

  // half decode for the scale multiply
  logic [4:0]  w_ef, a_ef;
  logic [9:0]  w_mf, a_mf;
  logic        w_nan, a_nan, w_inf, a_inf, w_zero, a_zero;
  logic [10:0] w_sig, a_sig;
  logic [4:0]  w_e1, a_e1;

  always_comb begin
    w_ef   = ws[14:10];
    a_ef   = as[14:10];
    w_mf   = ws[9:0];
    a_mf   = as[9:0];
    w_nan  = (w_ef == 5'h1F) && (w_mf != '0);
    a_nan  = (a_ef == 5'h1F) && (a_mf != '0);
    w_inf  = (w_ef == 5'h1F) && (w_mf == '0);
    a_inf  = (a_ef == 5'h1F) && (a_mf == '0);
    w_zero = (w_ef == '0) && (w_mf == '0);
    a_zero = (a_ef == '0) && (a_mf == '0);
    w_sig  = {w_ef != '0, w_mf};
    a_sig  = {a_ef != '0, a_mf};
    w_e1   = (w_ef == '0) ? 5'd1 : w_ef;
    a_e1   = (a_ef == '0) ? 5'd1 : a_ef;
  end

  // term rounding
  logic [41:0] tn;
  logic [23:0] tmant;
  logic        tinc;
  logic [8:0]  texp;
  logic [30:0] trnd;

  always_comb begin
    tn    = pp << psh;
    tmant = tn[41:18];
    tinc  = tn[17] & ((|tn[16:0]) | tmant[0]);
    texp  = 9'd118 + 9'(esum) - 9'(psh);
    trnd  = {texp[7:0], tmant[22:0]} + 31'(tinc);
  end

  // alignment and special cases of the add
  logic        c_anan, c_tnan, c_ainf, c_tinf, c_azero, c_tzero, c_swap;
  logic [31:0] c_x, c_y;
  logic [7:0]  c_xe, c_ye, c_d;
  logic [5:0]  c_dcl;
  logic [23:0] c_xm, c_ym;
  logic [49:0] c_z;
  logic        c_sp;
  logic [31:0] c_spres;

  always_comb begin
    c_anan  = (acc[30:23] == 8'hFF) && (acc[22:0] != '0);
    c_tnan  = (term[30:23] == 8'hFF) && (term[22:0] != '0);
    c_ainf  = (acc[30:23] == 8'hFF) && (acc[22:0] == '0);
    c_tinf  = (term[30:23] == 8'hFF) && (term[22:0] == '0);
    c_azero = (acc[30:0] == '0);
    c_tzero = (term[30:0] == '0);
    c_sp    = c_anan | c_tnan | c_ainf | c_tinf | c_azero | c_tzero;
    if (c_anan || c_tnan || (c_ainf && c_tinf && (acc[31] != term[31]))) begin
      c_spres = CANON_NAN;
    end else if (c_ainf) begin
      c_spres = acc;
    end else if (c_tinf) begin
      c_spres = term;
    end else if (c_azero && c_tzero) begin
      c_spres = {acc[31] & term[31], 31'b0};
    end else if (c_azero) begin
      c_spres = term;
    end else begin
      c_spres = acc;
    end
    c_swap = (term[30:0] > acc[30:0]);
    c_x    = c_swap ? term : acc;
    c_y    = c_swap ? acc : term;
    c_xe   = (c_x[30:23] == '0) ? 8'd1 : c_x[30:23];
    c_ye   = (c_y[30:23] == '0) ? 8'd1 : c_y[30:23];
    c_xm   = {c_x[30:23] != '0, c_x[22:0]};
    c_ym   = {c_y[30:23] != '0, c_y[22:0]};
    c_d    = c_xe - c_ye;
    c_dcl  = (c_d > 8'd50) ? 6'd50 : c_d[5:0];
    c_z    = {c_ym, 26'b0} >> c_dcl;
  end

  // final normalise and round
  logic [26:0] r_l;
  logic [23:0] r_mant;
  logic        r_inc;
  logic [8:0]  r_e, r_e9;
  logic [31:0] r_pre;
  logic [31:0] r_res;

  always_comb begin
    r_l = rr[26:0] << shl;
    if (rmode) begin
      r_mant = rr[27:4];
      r_inc  = rr[3] & ((|rr[2:0]) | r_mant[0]);
      r_e    = 9'(xe) + 9'd1;
    end else begin
      r_mant = r_l[26:3];
      r_inc  = r_l[2] & ((|r_l[1:0]) | r_mant[0]);
      r_e    = 9'(xe) - 9'(shl);
    end
    r_e9  = r_mant[23] ? r_e : 9'd0;
    r_pre = {r_e9, r_mant[22:0]} + 32'(r_inc);
    if (sp) begin
      r_res = spres;
    end else if (rzero) begin
      r_res = '0;
    end else if (r_pre[31:23] >= 9'd255) begin
      r_res = {xs, 8'hFF, 23'b0};
    end else begin
      r_res = {xs, r_pre[30:0]};
    end
  end

  logic [4:0] l_lz;
  logic [4:0] l_lim;

  always_comb begin
    l_lz  = lead_zeros(rr[26:0]);
    l_lim = (xe > 8'd28) ? 5'd27 : 5'(xe - 8'd1);
  end

  logic emit;
  assign emit = (state == F_DONE) && row && (!dot_valid || !dot_stall);
  assign busy = (state != F_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE:  if (req.start) state_next = F_MUL1;
      F_MUL1:  state_next = F_MUL2;
      F_MUL2:  state_next = F_LZC;
      F_LZC:   state_next = F_TERM;
      F_TERM:  state_next = F_ALIGN;
      F_ALIGN: state_next = F_ADD;
      F_ADD:   state_next = F_LZC2;
      F_LZC2:  state_next = F_ROUND;
      F_ROUND: state_next = F_DONE;
      F_DONE:  if (!row || emit) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      dot_valid <= 1'b0;
    end else begin
      if (state == F_ROUND) acc <= r_res;
      if (emit) begin
        acc       <= '0;
        dot_valid <= 1'b1;
      end else if (!dot_stall) begin
        dot_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      F_IDLE: begin
        if (req.start) begin
          row  <= req.row;
          bsum <= req.sum;
          ws   <= req.wscale;
          as   <= req.ascale;
        end
      end
      F_MUL1: begin
        sabs  <= bsum[SUM_W-1] ? SUM_W'(-bsum) : SUM_W'(bsum);
        mm    <= w_sig * a_sig;
        esum  <= 6'(w_e1) + 6'(a_e1);
        tsign <= bsum[SUM_W-1] ^ ws[15] ^ as[15];
        t_nan <= w_nan | a_nan |
                 ((w_inf | a_inf) & (w_zero | a_zero | (bsum == '0)));
        t_inf <= w_inf | a_inf;
      end
      F_MUL2: pp <= 42'(sabs) * 42'(mm);
      F_LZC: begin
        psh   <= 6'd41 - lead_pos(pp);
        pzero <= (pp == '0);
      end
      F_TERM: begin
        if (t_nan) term <= CANON_NAN;
        else if (t_inf) term <= {tsign, 8'hFF, 23'b0};
        else if (pzero) term <= {tsign, 31'b0};
        else term <= {tsign, trnd};
      end
      F_ALIGN: begin
        sp    <= c_sp;
        spres <= c_spres;
        xa    <= {c_xm, 3'b0};
        ya    <= {c_z[49:24], |c_z[23:0]};
        xe    <= c_xe;
        xs    <= c_x[31];
        sub   <= c_x[31] ^ c_y[31];
      end
      F_ADD: rr <= sub ? ({1'b0, xa} - {1'b0, ya}) : ({1'b0, xa} + {1'b0, ya});
      F_LZC2: begin
        rmode <= rr[27];
        rzero <= (rr == '0);
        // stop at the subnormal boundary
        shl   <= (l_lz > l_lim) ? l_lim : l_lz;
      end
      default: ;
    endcase
    if (emit) begin
      dot_value <= ((acc[30:23] == 8'hFF) && (acc[22:0] != '0)) ? CANON_NAN : acc;
    end
  end

endmodule
